// ===== hw/rtl/spf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spf_pkg;

   // Default pool depth
   localparam int CAPACITY_DEF = 64;

   // Operation codes carried in the request
   typedef enum logic [1:0] {
      FN_INSERT = 2'd0,
      FN_LIST   = 2'd1,
      FN_PREFIX = 2'd2,
      FN_OCTET  = 2'd3
   } func_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_MATCH  = 2'd0,
      ST_ACCEPT = 2'd1,
      ST_FULL   = 2'd2,
      ST_NONE   = 2'd3
   } status_type;

   // Controller states
   typedef enum logic {
      S_IDLE = 1'b0,
      S_SCAN = 1'b1
   } state_type;

   // Request transaction
   typedef struct packed {
      func_type    func;
      logic [31:0] address;
      logic [2:0]  prefix_octets;
      logic [7:0]  octet_value;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic [31:0] address_res;
      status_type  status;
      logic        last;
   } rsp_type;

   // Command broadcast to every cell of the chain
   typedef struct packed {
      logic        insert;
      logic        rotate;
      logic [31:0] addr;
   } cmd_type;

   // Leading-octet mask; lengths outside 1..4 clamp to the nearest end
   function automatic logic [31:0] prefix_mask(input logic [2:0] plen);
      logic [31:0] m;
      case (plen) inside
         3'd0, 3'd1: m = 32'hFF00_0000;
         3'd2:       m = 32'hFFFF_0000;
         3'd3:       m = 32'hFFFF_FF00;
         default:    m = 32'hFFFF_FFFF;
      endcase
      return m;
   endfunction

   // Query match test for one pool entry
   function automatic logic entry_hit(input func_type f, input logic [31:0] e,
                                      input logic [31:0] key, input logic [31:0] mask,
                                      input logic [7:0] oct);
      logic h;
      case (f)
         FN_LIST:   h = 1'b1;
         FN_PREFIX: h = ((e & mask) == (key & mask));
         FN_OCTET:  h = (e[31:24] == oct) || (e[23:16] == oct) ||
                        (e[15:8] == oct) || (e[7:0] == oct);
         default:   h = 1'b0;
      endcase
      return h;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/spf_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One slot of the sorted chain
module spf_cell (
   input  wire logic             clock,
   input  wire spf_pkg::cmd_type cmd,
   input  wire logic             occupied,    // slot lies below the fill count
   input  wire logic             is_tail,     // slot holds the last valid entry
   input  wire logic             prev_keep,   // upstream slot keeps its entry
   input  wire logic [31:0]      prev_entry,
   input  wire logic [31:0]      next_entry,
   input  wire logic [31:0]      head_entry,
   output logic                  keep,
   output logic [31:0]           entry
);

   logic [31:0] entry_ff;
   logic [31:0] entry_in;

   assign entry = entry_ff;

   // Entry stays put when it sorts at or ahead of the new address
   assign keep = occupied && (entry_ff >= cmd.addr);

   // Insert shifts down behind the insertion point; rotate moves toward the head
   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert) begin
         if (keep) begin
            entry_in = entry_ff;
         end else if (prev_keep) begin
            entry_in = cmd.addr;
         end else begin
            entry_in = prev_entry;
         end
      end else if (cmd.rotate) begin
         entry_in = is_tail ? head_entry : next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/ipv4_sorted_pool_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload            Handshake
// req_      in         spf_pkg::req_type  req_valid / req_ready
// rsp_      out        spf_pkg::rsp_type  rsp_valid / rsp_ready
//
// Insert: the chain of cells shifts the new address into place.
// Query: the accept step, then the scan rotating the valid entries past the head
// cell, and a closing step in which the one-deep hold register releases the result
// with last.
// Reset empties the pool at once (fill count only, no clearing pass).
// A stalled result register halts the scan; a new request waits for idle.
module ipv4_sorted_pool_filter #(
   parameter int CAPACITY = spf_pkg::CAPACITY_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire spf_pkg::req_type  req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output spf_pkg::rsp_type       rsp_payload
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   spf_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   spf_pkg::func_type  func_ff, func_in;
   logic [31:0]        key_ff, key_in;
   logic [31:0]        mask_ff, mask_in;
   logic [7:0]         oct_ff, oct_in;
   logic [31:0]        hold_ff, hold_in;
   logic               hold_valid_ff, hold_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   spf_pkg::rsp_type   rsp_ff, rsp_in;

   spf_pkg::cmd_type   cmd;
   logic               out_free;
   logic               accept;
   logic               push;
   logic [31:0]        head;

   logic [31:0] entry_w [CAPACITY];
   logic        keep_w  [CAPACITY];

   // Chain of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [CNT_W-1:0] IDX  = CNT_W'(i);
      localparam logic [CNT_W-1:0] IDX1 = CNT_W'(i + 1);
      logic        prev_keep;
      logic [31:0] prev_entry;
      logic [31:0] next_entry;

      if (i == 0) begin : g_first
         assign prev_keep  = 1'b1;
         assign prev_entry = 32'd0;
      end else begin : g_mid
         assign prev_keep  = keep_w[i-1];
         assign prev_entry = entry_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign next_entry = head;
      end else begin : g_body
         assign next_entry = entry_w[i+1];
      end

      spf_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .occupied   (IDX < count_ff),
         .is_tail    (IDX1 == count_ff),
         .prev_keep  (prev_keep),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .head_entry (head),
         .keep       (keep_w[i]),
         .entry      (entry_w[i])
      );
   end

   assign head      = entry_w[0];
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == spf_pkg::S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Controller: next state, chain command and result push
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rem_in        = rem_ff;
      func_in       = func_ff;
      key_in        = key_ff;
      mask_in       = mask_ff;
      oct_in        = oct_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      rsp_in        = rsp_ff;
      push          = 1'b0;
      cmd.insert    = 1'b0;
      cmd.rotate    = 1'b0;
      cmd.addr      = req_payload.address;

      case (state_ff)
         spf_pkg::S_IDLE: begin
            if (accept) begin
               if (req_payload.func == spf_pkg::FN_INSERT) begin
                  push                = 1'b1;
                  rsp_in.address_res  = 32'd0;
                  rsp_in.last         = 1'b1;
                  if (count_ff == CNT_W'(CAPACITY)) begin
                     rsp_in.status = spf_pkg::ST_FULL;
                  end else begin
                     rsp_in.status = spf_pkg::ST_ACCEPT;
                     cmd.insert    = 1'b1;
                     count_in      = count_ff + 1'b1;
                  end
               end else begin
                  func_in       = req_payload.func;
                  key_in        = req_payload.address;
                  mask_in       = spf_pkg::prefix_mask(req_payload.prefix_octets);
                  oct_in        = req_payload.octet_value;
                  rem_in        = count_ff;
                  hold_valid_in = 1'b0;
                  state_in      = spf_pkg::S_SCAN;
               end
            end
         end
         spf_pkg::S_SCAN: begin
            if (out_free) begin
               if (rem_ff != '0) begin
                  // Examine the head entry and rotate it to the tail
                  cmd.rotate = 1'b1;
                  rem_in     = rem_ff - 1'b1;
                  if (spf_pkg::entry_hit(func_ff, head, key_ff, mask_ff, oct_ff)) begin
                     if (hold_valid_ff) begin
                        push               = 1'b1;
                        rsp_in.address_res = hold_ff;
                        rsp_in.status      = spf_pkg::ST_MATCH;
                        rsp_in.last        = 1'b0;
                     end
                     hold_in       = head;
                     hold_valid_in = 1'b1;
                  end
               end else begin
                  // End of scan: release the held match or report none
                  push        = 1'b1;
                  rsp_in.last = 1'b1;
                  if (hold_valid_ff) begin
                     rsp_in.address_res = hold_ff;
                     rsp_in.status      = spf_pkg::ST_MATCH;
                  end else begin
                     rsp_in.address_res = 32'd0;
                     rsp_in.status      = spf_pkg::ST_NONE;
                  end
                  hold_valid_in = 1'b0;
                  state_in      = spf_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = spf_pkg::S_IDLE;
         end
      endcase

      // Output register occupancy
      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= spf_pkg::S_IDLE;
         count_ff      <= '0;
         rem_ff        <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rem_ff        <= rem_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      func_ff <= func_in;
      key_ff  <= key_in;
      mask_ff <= mask_in;
      oct_ff  <= oct_in;
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

endmodule

`default_nettype wire

// ===== test/spf_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the address pool, keeps its own sorted copy of the
// pool and checks every result transaction against the predicted sequence.
module spf_checker #(
   parameter int POOL_DEPTH = spf_pkg::CAPACITY_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  spf_pkg::req_type req_payload,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  spf_pkg::rsp_type rsp_payload,
   output int              mismatch_count,
   output int              answers_due
);
   import spf_pkg::*;

   // Shadow pool, highest address first
   logic [31:0] pool_entries [POOL_DEPTH];
   int          pool_fill = 0;
   rsp_type     pool_answers [$];
   int          mismatches = 0;
   rsp_type     got;
   rsp_type     want;

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("spf_checker: %0t ns: %s", $time, what);
   endtask

   function automatic logic holds_octet(input logic [31:0] a, input logic [7:0] v);
      return (a[31:24] == v) || (a[23:16] == v) || (a[15:8] == v) || (a[7:0] == v);
   endfunction

   // Apply one request to the shadow pool and queue the answers it must give
   task automatic pool_operation(input req_type r);
      rsp_type     ans;
      logic [31:0] mask;
      logic [31:0] matched [$];
      int          slot;
      int          nbytes;
      logic        hit;
      ans = '0;
      if (r.func == FN_INSERT) begin
         ans.last = 1'b1;
         if (pool_fill >= POOL_DEPTH) begin
            ans.status = ST_FULL;
         end else begin
            // new address lands after any equal ones
            slot = 0;
            while (slot < pool_fill && pool_entries[slot] >= r.address)
               slot++;
            for (int i = pool_fill; i > slot; i--)
               pool_entries[i] = pool_entries[i - 1];
            pool_entries[slot] = r.address;
            pool_fill++;
            ans.status = ST_ACCEPT;
         end
         pool_answers = {pool_answers, ans};
      end else begin
         // prefix length clamps into 1..4 octets
         if (r.prefix_octets == 3'd0)
            nbytes = 1;
         else if (r.prefix_octets > 3'd4)
            nbytes = 4;
         else
            nbytes = int'(r.prefix_octets);
         mask = 32'hFFFF_FFFF << (32 - 8 * nbytes);
         for (int i = 0; i < pool_fill; i++) begin
            case (r.func)
               FN_LIST:   hit = 1'b1;
               FN_PREFIX: hit = ((pool_entries[i] ^ r.address) & mask) == 32'd0;
               default:   hit = holds_octet(pool_entries[i], r.octet_value);
            endcase
            if (hit)
               matched = {matched, pool_entries[i]};
         end
         if (matched.size() == 0) begin
            ans.status = ST_NONE;
            ans.last = 1'b1;
            pool_answers = {pool_answers, ans};
         end else begin
            for (int i = 0; i < matched.size(); i++) begin
               ans.address_res = matched[i];
               ans.status = ST_MATCH;
               ans.last = (i == matched.size() - 1);
               pool_answers = {pool_answers, ans};
            end
         end
      end
   endtask

   // Requests are applied before results so a same-edge pair stays in order
   always @(posedge clock) begin
      if (reset) begin
         pool_fill = 0;
         pool_answers.delete();
      end else begin
         if (req_valid && req_ready)
            pool_operation(req_payload);
         if (rsp_valid && rsp_ready) begin
            got = rsp_payload;
            if (pool_answers.size() == 0) begin
               report_mismatch($sformatf("result with none pending: addr %08h status %0d last %0b",
                                         got.address_res, got.status, got.last));
            end else begin
               want = pool_answers.pop_front();
               if (got.address_res !== want.address_res)
                  report_mismatch($sformatf("address_res %08h, predicted %08h",
                                            got.address_res, want.address_res));
               if (got.status !== want.status)
                  report_mismatch($sformatf("status %0d, predicted %0d (addr %08h)",
                                            got.status, want.status, want.address_res));
               if (got.last !== want.last)
                  report_mismatch($sformatf("last %0b, predicted %0b (addr %08h)",
                                            got.last, want.last, want.address_res));
            end
         end
      end
      answers_due <= pool_answers.size();
      mismatch_count <= mismatches;
   end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import spf_pkg::*;

   localparam int ITEM_COUNT       = 280;
   localparam int CYCLE_LIMIT      = 1_200_000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES     = 80;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;
   int      mismatch_count;
   int      answers_due;
   int      cycle_count = 0;
   bit      calm = 1'b0;           // no idling on either side
   bit      hold_request = 1'b0;
   bit      hold_served = 1'b0;
   logic [31:0] inserted [$];      // addresses sent for insert, for keys and duplicates

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   ipv4_sorted_pool_filter #(
      .CAPACITY(CAPACITY_DEF)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   spf_checker #(
      .POOL_DEPTH(CAPACITY_DEF)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .mismatch_count(mismatch_count),
      .answers_due   (answers_due)
   );

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // Result side: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request && !hold_served) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_served <= 1'b1;
            rsp_ready <= 1'b1;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic req_type make_request(input func_type f, input logic [31:0] a,
                                            input logic [2:0] plen, input logic [7:0] oct);
      req_type r;
      r.func = f;
      r.address = a;
      r.prefix_octets = plen;
      r.octet_value = oct;
      return r;
   endfunction

   // Addresses clustered in a few networks so prefix queries find matches
   function automatic logic [31:0] pick_address();
      logic [31:0] a;
      a = $urandom;
      case ($urandom_range(0, 5))
         0: a[31:8] = 24'hC0A801;
         1: a[31:16] = 16'h0A00;
         2: a[31:24] = 8'hAC;
         3: if (inserted.size() != 0) a = inserted[$urandom_range(0, inserted.size() - 1)];
         default: ;
      endcase
      return a;
   endfunction

   function automatic req_type random_request();
      req_type     r;
      logic [31:0] src;
      int          pick;
      pick = $urandom_range(0, 9);
      if (pick < 4)
         r.func = FN_INSERT;
      else if (pick < 6)
         r.func = FN_LIST;
      else if (pick < 8)
         r.func = FN_PREFIX;
      else
         r.func = FN_OCTET;
      r.address = pick_address();
      // mostly legal prefix lengths, sometimes the clamped ones
      if ($urandom_range(0, 3) == 0)
         r.prefix_octets = 3'($urandom_range(0, 7));
      else
         r.prefix_octets = 3'($urandom_range(1, 4));
      if (inserted.size() != 0 && $urandom_range(0, 1) == 0) begin
         src = inserted[$urandom_range(0, inserted.size() - 1)];
         r.octet_value = src[8 * $urandom_range(0, 3) +: 8];
      end else begin
         r.octet_value = 8'($urandom);
      end
      return r;
   endfunction

   // Offer one transaction and hold it until accepted
   task automatic send_request(input req_type r);
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      if (r.func == FN_INSERT)
         inserted = {inserted, r.address};
   endtask

   task automatic pause_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (answers_due != 0);
   endtask

   // Stimulus and verdict
   initial begin
      bit quiet;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // queries on the empty pool
      send_request(make_request(FN_LIST,   32'h0000_0000, 3'd1, 8'h00));
      send_request(make_request(FN_PREFIX, 32'hFFFF_FFFF, 3'd4, 8'hFF));
      send_request(make_request(FN_OCTET,  32'h0000_0000, 3'd0, 8'h00));
      // extremes and a duplicate
      send_request(make_request(FN_INSERT, 32'h0000_0000, 3'd7, 8'hFF));
      send_request(make_request(FN_INSERT, 32'hFFFF_FFFF, 3'd0, 8'h00));
      send_request(make_request(FN_INSERT, 32'hC0A8_0101, 3'd1, 8'h00));
      send_request(make_request(FN_INSERT, 32'hC0A8_0101, 3'd1, 8'h00));
      send_request(make_request(FN_INSERT, 32'h0A00_0001, 3'd1, 8'h00));
      send_request(make_request(FN_INSERT, 32'hC0A8_0201, 3'd1, 8'h00));
      send_request(make_request(FN_LIST,   32'hFFFF_FFFF, 3'd7, 8'hFF));
      // prefix lengths, including the clamped ones
      send_request(make_request(FN_PREFIX, 32'hC0A8_0000, 3'd2, 8'h00));
      send_request(make_request(FN_PREFIX, 32'hC000_0000, 3'd0, 8'h00));
      send_request(make_request(FN_PREFIX, 32'hC0A8_0101, 3'd7, 8'h00));
      send_request(make_request(FN_PREFIX, 32'hC0A8_01FF, 3'd3, 8'h00));
      send_request(make_request(FN_PREFIX, 32'hFF12_3456, 3'd1, 8'h00));
      send_request(make_request(FN_PREFIX, 32'hC0A8_0201, 3'd5, 8'h00));
      send_request(make_request(FN_PREFIX, 32'h0102_0304, 3'd4, 8'h00));
      send_request(make_request(FN_PREFIX, 32'h0A00_0001, 3'd6, 8'h00));
      // any-octet searches, one with no match
      send_request(make_request(FN_OCTET,  32'h0000_0000, 3'd1, 8'h01));
      send_request(make_request(FN_OCTET,  32'h0000_0000, 3'd1, 8'hFF));
      send_request(make_request(FN_OCTET,  32'h0000_0000, 3'd1, 8'h00));
      send_request(make_request(FN_OCTET,  32'hFFFF_FFFF, 3'd1, 8'h77));

      // random traffic; the pool fills up partway and later inserts come back full
      for (int i = 0; i < ITEM_COUNT; i++) begin
         quiet = (i >= 60 && i < 85) || (i >= ITEM_COUNT - 40);
         calm <= quiet;
         if (i == 110)
            hold_request <= 1'b1;
         if (i == 200)
            wait_drained();
         else if (!quiet && $urandom_range(0, 3) == 0)
            pause_sender($urandom_range(1, 12));
         send_request(random_request());
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
